[rtl/rcp_pkg.sv]
package rcp_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int FRAC_BITS     = 16;
  localparam int GUARD_BITS    = 6;

  localparam int DATA_W = 32;
  localparam int ANG_W  = 19;
  localparam int MAG_W  = 33;

  localparam int GAIN_FRAC = 24;
  localparam int GAIN_W    = GAIN_FRAC + 1;

  localparam int XW        = DATA_W + GUARD_BITS + 3;
  localparam int ZW        = 42;
  localparam int ANG_SHIFT = 32 - FRAC_BITS;
  localparam int SHIFT_W   = $clog2(CORDIC_STAGES);
  localparam int LO_W      = XW / 2;
  localparam int PROD_W    = DATA_W + GAIN_W;
  localparam int SUM_W     = XW + GAIN_W;

  localparam logic signed [GAIN_W-1:0] GAIN = GAIN_W'(24'd10188014);

  localparam logic signed [ZW-1:0] PI_Q32      = ZW'(36'h3243F6A89);
  localparam logic signed [ZW-1:0] HALF_PI_Q32 = ZW'(36'h1921FB544);
  localparam logic signed [ZW-1:0] TWO_PI_Q32  = ZW'(40'h6487ED5111);
  localparam logic [35:0]          TWO_PI_Q28  = 36'h6487ED511;

  localparam logic signed [ZW-1:0] ANG_RND = ZW'(1) <<< (31 - FRAC_BITS);
  localparam logic signed [ZW-1:0] PI_F    = (PI_Q32 + ANG_RND) >>> ANG_SHIFT;

  localparam logic signed [MAG_W-1:0] MAG_MAX = MAG_W'(33'd3037000500);

  typedef enum logic [0:0] {
    OP_TO_POLAR = 1'b0,
    OP_TO_RECT  = 1'b1
  } rcp_op_e;

  typedef struct packed {
    rcp_op_e                 op;
    logic                    zero;
    logic signed [XW-1:0]    x;
    logic signed [XW-1:0]    y;
    logic signed [ZW-1:0]    z;
    logic [DATA_W-1:0]       echo_a;
    logic [DATA_W-1:0]       echo_b;
  } rcp_data_t;

  localparam logic [31:0] TURN_ATAN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  function automatic logic signed [ZW-1:0] atan_rad(input int unsigned i);
    logic [67:0] prod;
    prod = 68'(TURN_ATAN[i[4:0]]) * 68'(TWO_PI_Q28);
    return ZW'(prod >> 28);
  endfunction

endpackage

[rtl/rcp_prep.sv]
module rcp_prep (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic                                 op_i,
  input  logic signed [rcp_pkg::DATA_W-1:0]    real_in_i,
  input  logic signed [rcp_pkg::DATA_W-1:0]    imag_in_i,
  input  logic signed [rcp_pkg::DATA_W-1:0]    mag_in_i,
  input  logic signed [rcp_pkg::ANG_W-1:0]     angle_in_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output rcp_pkg::rcp_data_t                   data_o
);

  localparam int ROT_SHIFT = rcp_pkg::GAIN_FRAC - rcp_pkg::GUARD_BITS;
  localparam logic signed [rcp_pkg::PROD_W-1:0] ROT_RND =
      rcp_pkg::PROD_W'(1) <<< (ROT_SHIFT - 1);

  typedef struct packed {
    rcp_pkg::rcp_op_e                         op;
    logic                                     zero;
    logic signed [rcp_pkg::XW-1:0]            x;
    logic signed [rcp_pkg::XW-1:0]            y;
    logic signed [rcp_pkg::ZW-1:0]            z;
    logic signed [rcp_pkg::PROD_W-1:0]        prod;
    logic [rcp_pkg::DATA_W-1:0]               echo_a;
    logic [rcp_pkg::DATA_W-1:0]               echo_b;
  } stage_a_t;

  stage_a_t                          a_d, a_q;
  logic                              a_valid_q;
  rcp_pkg::rcp_data_t                b_d, b_q;
  logic                              b_valid_q;
  logic                              ready_b;

  logic                              neg;
  logic signed [rcp_pkg::DATA_W:0]   xe, ye, xa, ya;
  logic signed [rcp_pkg::XW-1:0]     xw, yw;
  logic signed [rcp_pkg::ZW-1:0]     zr;

  logic                              flip;
  logic signed [rcp_pkg::ZW-1:0]     zf;
  logic signed [rcp_pkg::PROD_W-1:0] rsum;

  assign ready_b = !b_valid_q || ready_i;
  assign ready_o = !a_valid_q || ready_b;

  always_comb begin
    neg = real_in_i[rcp_pkg::DATA_W-1];
    xe  = {real_in_i[rcp_pkg::DATA_W-1], real_in_i};
    ye  = {imag_in_i[rcp_pkg::DATA_W-1], imag_in_i};
    xa  = neg ? -xe : xe;
    ya  = neg ? -ye : ye;
    xw  = rcp_pkg::XW'(xa);
    yw  = rcp_pkg::XW'(ya);
    zr  = rcp_pkg::ZW'(angle_in_i) <<< rcp_pkg::ANG_SHIFT;

    a_d.op   = rcp_pkg::rcp_op_e'(op_i);
    a_d.zero = (real_in_i == '0) && (imag_in_i == '0);
    a_d.x    = xw <<< rcp_pkg::GUARD_BITS;
    a_d.y    = yw <<< rcp_pkg::GUARD_BITS;
    a_d.prod = mag_in_i * rcp_pkg::GAIN;
    if (a_d.op == rcp_pkg::OP_TO_RECT) begin
      a_d.z      = (zr < -rcp_pkg::PI_Q32) ? zr + rcp_pkg::TWO_PI_Q32 : zr;
      a_d.echo_a = mag_in_i;
      a_d.echo_b = {{(rcp_pkg::DATA_W - rcp_pkg::ANG_W){angle_in_i[rcp_pkg::ANG_W-1]}},
                    angle_in_i};
    end else begin
      if (neg) begin
        a_d.z = imag_in_i[rcp_pkg::DATA_W-1] ? -rcp_pkg::PI_Q32 : rcp_pkg::PI_Q32;
      end else begin
        a_d.z = '0;
      end
      a_d.echo_a = real_in_i;
      a_d.echo_b = imag_in_i;
    end
  end

  always_comb begin
    flip = (a_q.z > rcp_pkg::HALF_PI_Q32) || (a_q.z < -rcp_pkg::HALF_PI_Q32);
    if (a_q.z > rcp_pkg::HALF_PI_Q32) begin
      zf = a_q.z - rcp_pkg::PI_Q32;
    end else if (a_q.z < -rcp_pkg::HALF_PI_Q32) begin
      zf = a_q.z + rcp_pkg::PI_Q32;
    end else begin
      zf = a_q.z;
    end
    // negate by complement: -floor(v) folds into the same rounding add
    rsum = (flip ? ~a_q.prod : a_q.prod) + ROT_RND;

    b_d.op     = a_q.op;
    b_d.zero   = a_q.zero;
    b_d.echo_a = a_q.echo_a;
    b_d.echo_b = a_q.echo_b;
    if (a_q.op == rcp_pkg::OP_TO_RECT) begin
      b_d.x = rcp_pkg::XW'(rsum >>> ROT_SHIFT);
      b_d.y = '0;
      b_d.z = zf;
    end else begin
      b_d.x = a_q.x;
      b_d.y = a_q.y;
      b_d.z = a_q.z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        a_valid_q <= valid_i;
      end
      if (ready_b) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_q <= a_d;
    end
    if (ready_b && a_valid_q) begin
      b_q <= b_d;
    end
  end

  assign valid_o = b_valid_q;
  assign data_o  = b_q;

endmodule

[rtl/rcp_cell.sv]
module rcp_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [rcp_pkg::SHIFT_W-1:0]        shift_i,
  input  logic signed [rcp_pkg::ZW-1:0]      atan_i,
  input  logic                               valid_i,
  output logic                               ready_o,
  input  rcp_pkg::rcp_data_t                 data_i,
  output logic                               valid_o,
  input  logic                               ready_i,
  output rcp_pkg::rcp_data_t                 data_o
);

  rcp_pkg::rcp_data_t            data_d, data_q;
  logic                          valid_q;
  logic signed [rcp_pkg::XW-1:0] xs, ys;
  logic                          step_pos;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    xs = data_i.x >>> shift_i;
    ys = data_i.y >>> shift_i;
    if (data_i.op == rcp_pkg::OP_TO_RECT) begin
      step_pos = !data_i.z[rcp_pkg::ZW-1];
    end else begin
      step_pos = data_i.y[rcp_pkg::XW-1];
    end
    data_d = data_i;
    if (step_pos) begin
      data_d.x = data_i.x - ys;
      data_d.y = data_i.y + xs;
      data_d.z = data_i.z - atan_i;
    end else begin
      data_d.x = data_i.x + ys;
      data_d.y = data_i.y - xs;
      data_d.z = data_i.z + atan_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[rtl/rcp_post.sv]
module rcp_post (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  rcp_pkg::rcp_data_t                   data_i,
  output logic                                 valid_o,
  input  logic                                 stall_i,
  output logic signed [rcp_pkg::DATA_W-1:0]    real_out_o,
  output logic signed [rcp_pkg::DATA_W-1:0]    imag_out_o,
  output logic signed [rcp_pkg::MAG_W-1:0]     mag_out_o,
  output logic signed [rcp_pkg::ANG_W-1:0]     angle_out_o
);

  localparam int HI_W  = rcp_pkg::XW - rcp_pkg::LO_W;
  localparam int PLO_W = rcp_pkg::LO_W + rcp_pkg::GAIN_FRAC;
  localparam int PHI_W = HI_W + rcp_pkg::GAIN_W;
  localparam int MAG_SHIFT = rcp_pkg::GAIN_FRAC + rcp_pkg::GUARD_BITS;

  localparam logic signed [rcp_pkg::XW-1:0] G_RND =
      rcp_pkg::XW'(1) <<< (rcp_pkg::GUARD_BITS - 1);
  localparam logic signed [rcp_pkg::XW-1:0] S_MAX =
      (rcp_pkg::XW'(1) <<< (rcp_pkg::DATA_W - 1)) - 1;
  localparam logic signed [rcp_pkg::XW-1:0] S_MIN =
      -(rcp_pkg::XW'(1) <<< (rcp_pkg::DATA_W - 1));
  localparam logic signed [rcp_pkg::SUM_W-1:0] MAG_RND =
      rcp_pkg::SUM_W'(1) <<< (MAG_SHIFT - 1);

  typedef struct packed {
    rcp_pkg::rcp_op_e                      op;
    logic [PLO_W-1:0]                      p_lo;
    logic signed [PHI_W-1:0]               p_hi;
    logic signed [rcp_pkg::ANG_W-1:0]      ang;
    logic signed [rcp_pkg::DATA_W-1:0]     re;
    logic signed [rcp_pkg::DATA_W-1:0]     im;
    logic [rcp_pkg::DATA_W-1:0]            echo_a;
    logic [rcp_pkg::DATA_W-1:0]            echo_b;
  } stage_c_t;

  stage_c_t                             c_d, c_q;
  logic                                 c_valid_q;
  logic                                 d_valid_q;
  logic                                 ready_d;

  logic signed [rcp_pkg::ZW-1:0]        az;
  logic signed [rcp_pkg::XW-1:0]        rx, ry;

  logic signed [rcp_pkg::SUM_W-1:0]     sum, m;
  logic signed [rcp_pkg::DATA_W-1:0]    real_d, real_q, imag_d, imag_q;
  logic signed [rcp_pkg::MAG_W-1:0]     mag_d, mag_q;
  logic signed [rcp_pkg::ANG_W-1:0]     angle_d, angle_q;

  assign ready_d = !d_valid_q || !stall_i;
  assign ready_o = !c_valid_q || ready_d;

  always_comb begin
    c_d.op     = data_i.op;
    c_d.echo_a = data_i.echo_a;
    c_d.echo_b = data_i.echo_b;
    c_d.p_lo   = data_i.x[rcp_pkg::LO_W-1:0] * rcp_pkg::GAIN[rcp_pkg::GAIN_FRAC-1:0];
    c_d.p_hi   = $signed(data_i.x[rcp_pkg::XW-1:rcp_pkg::LO_W]) * rcp_pkg::GAIN;

    az = (data_i.z + rcp_pkg::ANG_RND) >>> rcp_pkg::ANG_SHIFT;
    if (data_i.zero) begin
      c_d.ang = '0;
    end else if (az > rcp_pkg::PI_F) begin
      c_d.ang = rcp_pkg::ANG_W'(rcp_pkg::PI_F);
    end else if (az < -rcp_pkg::PI_F) begin
      c_d.ang = rcp_pkg::ANG_W'(-rcp_pkg::PI_F);
    end else begin
      c_d.ang = rcp_pkg::ANG_W'(az);
    end

    rx = (data_i.x + G_RND) >>> rcp_pkg::GUARD_BITS;
    ry = (data_i.y + G_RND) >>> rcp_pkg::GUARD_BITS;
    c_d.re = (rx > S_MAX) ? rcp_pkg::DATA_W'(S_MAX) :
             (rx < S_MIN) ? rcp_pkg::DATA_W'(S_MIN) : rcp_pkg::DATA_W'(rx);
    c_d.im = (ry > S_MAX) ? rcp_pkg::DATA_W'(S_MAX) :
             (ry < S_MIN) ? rcp_pkg::DATA_W'(S_MIN) : rcp_pkg::DATA_W'(ry);
  end

  always_comb begin
    sum = (rcp_pkg::SUM_W'(c_q.p_hi) <<< rcp_pkg::LO_W)
        + $signed(rcp_pkg::SUM_W'(c_q.p_lo)) + MAG_RND;
    m   = sum >>> MAG_SHIFT;
    if (c_q.op == rcp_pkg::OP_TO_RECT) begin
      real_d  = c_q.re;
      imag_d  = c_q.im;
      mag_d   = {c_q.echo_a[rcp_pkg::DATA_W-1], c_q.echo_a};
      angle_d = c_q.echo_b[rcp_pkg::ANG_W-1:0];
    end else begin
      real_d  = c_q.echo_a;
      imag_d  = c_q.echo_b;
      mag_d   = (m > rcp_pkg::SUM_W'(rcp_pkg::MAG_MAX)) ? rcp_pkg::MAG_MAX
                                                       : rcp_pkg::MAG_W'(m);
      angle_d = c_q.ang;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
      d_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        c_valid_q <= valid_i;
      end
      if (ready_d) begin
        d_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      c_q <= c_d;
    end
    if (ready_d && c_valid_q) begin
      real_q  <= real_d;
      imag_q  <= imag_d;
      mag_q   <= mag_d;
      angle_q <= angle_d;
    end
  end

  assign valid_o     = d_valid_q;
  assign real_out_o  = real_q;
  assign imag_out_o  = imag_q;
  assign mag_out_o   = mag_q;
  assign angle_out_o = angle_q;

endmodule

[rtl/rect_polar_converter.sv]
// Channel  | Dir | Handshake                | Payload
// ---------+-----+--------------------------+-------------------------------------------
// input    | in  | in_valid_i / in_stall_o  | op_i, real_in_i, imag_in_i, mag_in_i,
//          |     |                          | angle_in_i
// result   | out | out_valid_o / out_stall_i| real_out_o, imag_out_o, mag_out_o,
//          |     |                          | angle_out_o
//
// One item per cycle unless in_stall_o is high; the pipeline has two prep stages (gain multiply,
// quadrant fold), one cell per CORDIC micro-rotation (16), two output stages (split magnitude
// multiply, then the output register).
// Every stage has its own valid bit and loads when the next one is free, so bubbles
// collapse and in_stall_o rises only when all stages hold an item and out_stall_i is high.
// Reset clears the valid bits only; the data registers are not reset.
module rect_polar_converter (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic signed [rcp_pkg::DATA_W-1:0]    real_in_i,
  input  logic signed [rcp_pkg::DATA_W-1:0]    imag_in_i,
  input  logic signed [rcp_pkg::DATA_W-1:0]    mag_in_i,
  input  logic signed [rcp_pkg::ANG_W-1:0]     angle_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [rcp_pkg::DATA_W-1:0]    real_out_o,
  output logic signed [rcp_pkg::DATA_W-1:0]    imag_out_o,
  output logic signed [rcp_pkg::MAG_W-1:0]     mag_out_o,
  output logic signed [rcp_pkg::ANG_W-1:0]     angle_out_o
);

  localparam int N = rcp_pkg::CORDIC_STAGES;

  rcp_pkg::rcp_data_t link_data  [N+1];
  logic               link_valid [N+1];
  logic               link_ready [N+1];
  logic               prep_ready;

  rcp_prep u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .ready_o    (prep_ready),
    .op_i       (op_i),
    .real_in_i  (real_in_i),
    .imag_in_i  (imag_in_i),
    .mag_in_i   (mag_in_i),
    .angle_in_i (angle_in_i),
    .valid_o    (link_valid[0]),
    .ready_i    (link_ready[0]),
    .data_o     (link_data[0])
  );

  assign in_stall_o = !prep_ready;

  for (genvar k = 0; k < N; k++) begin : g_cell
    localparam logic signed [rcp_pkg::ZW-1:0] ATAN_K = rcp_pkg::atan_rad(k);

    rcp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (rcp_pkg::SHIFT_W'(k)),
      .atan_i  (ATAN_K),
      .valid_i (link_valid[k]),
      .ready_o (link_ready[k]),
      .data_i  (link_data[k]),
      .valid_o (link_valid[k+1]),
      .ready_i (link_ready[k+1]),
      .data_o  (link_data[k+1])
    );
  end

  rcp_post u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (link_valid[N]),
    .ready_o     (link_ready[N]),
    .data_i      (link_data[N]),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .real_out_o  (real_out_o),
    .imag_out_o  (imag_out_o),
    .mag_out_o   (mag_out_o),
    .angle_out_o (angle_out_o)
  );

endmodule

[rtl/rcp_checker.sv]
module rcp_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_stall_o,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic signed [rcp_pkg::DATA_W-1:0]    real_out_o,
  input logic signed [rcp_pkg::DATA_W-1:0]    imag_out_o,
  input logic signed [rcp_pkg::MAG_W-1:0]     mag_out_o,
  input logic signed [rcp_pkg::ANG_W-1:0]     angle_out_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(real_out_o) &&
      $stable(imag_out_o) && $stable(mag_out_o) && $stable(angle_out_o))
    else $error("stalled result transfer changed or dropped");

  a_mag_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> mag_out_o <= rcp_pkg::MAG_MAX)
    else $error("magnitude above clamp limit");

  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output side can drain");

  a_reset_clear: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o && !in_stall_o)
    else $error("pipeline not empty during reset");

endmodule

bind rect_polar_converter rcp_checker u_rcp_checker (.*);

[test/rect_polar_converter_test.sv]
`timescale 1ns / 100ps

module rect_polar_converter_test;

  localparam int N_ROT   = 16;
  localparam int Q_FRAC  = 16;
  localparam int G_BITS  = 6;
  localparam int ANG_SH  = 32 - Q_FRAC;
  localparam int N_DIR   = 25;
  localparam int N_RAND  = 1425;
  localparam int HOLD_AT  = 700;
  localparam int HOLD_LEN = 80;
  localparam int QUIET_LIMIT = 1000;
  localparam int DRAIN   = 30;

  localparam longint K_GAIN      = 10188014;
  localparam longint PI_RAD      = 64'sh3243F6A89;
  localparam longint HALF_PI_RAD = 64'sh1921FB544;
  localparam longint TWO_PI_RAD  = 64'sh6487ED5111;
  localparam longint MAG_CAP     = 64'sd3037000500;
  localparam longint unsigned TWO_PI_TURN = 64'h6487ED511;

  localparam logic signed [rcp_pkg::DATA_W-1:0] MAXP = 32'sh7FFFFFFF;
  localparam logic signed [rcp_pkg::DATA_W-1:0] MAXN = 32'sh80000000;
  localparam logic signed [rcp_pkg::ANG_W-1:0]  PI_A = 205887;

  localparam logic [31:0] ATAN_TURN [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C
  };

  localparam logic signed [rcp_pkg::DATA_W-1:0] EDGE_VALS [5] = '{MAXN, MAXP, 0, -1, 1};

  typedef struct packed {
    logic signed [rcp_pkg::DATA_W-1:0] re;
    logic signed [rcp_pkg::DATA_W-1:0] im;
    logic signed [rcp_pkg::MAG_W-1:0]  mag;
    logic signed [rcp_pkg::ANG_W-1:0]  ang;
  } conv_res_t;

  typedef struct packed {
    rcp_pkg::rcp_op_e                  op;
    logic signed [rcp_pkg::DATA_W-1:0] re;
    logic signed [rcp_pkg::DATA_W-1:0] im;
    logic signed [rcp_pkg::DATA_W-1:0] mag;
    logic signed [rcp_pkg::ANG_W-1:0]  ang;
    logic                              typed;
    conv_res_t                         want;
  } conv_req_t;

  localparam conv_req_t DIR_ROWS [N_DIR] = '{
    '{rcp_pkg::OP_TO_POLAR, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0}},
    '{rcp_pkg::OP_TO_POLAR, 0, 0, MAXP, -1, 1'b1, '{0, 0, 0, 0}},
    '{rcp_pkg::OP_TO_RECT, 0, 0, 0, 0, 1'b1, '{0, 0, 0, 0}},
    '{rcp_pkg::OP_TO_RECT, MAXN, MAXP, 0, PI_A, 1'b1, '{0, 0, 0, PI_A}},
    '{rcp_pkg::OP_TO_RECT, -1, 1, 0, -PI_A, 1'b1, '{0, 0, 0, -PI_A}},
    '{rcp_pkg::OP_TO_POLAR, 1, 0, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, 65536, 0, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, -65536, 0, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, -65536, -1, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, -65536, 1, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, 0, 65536, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, 0, -65536, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, MAXP, MAXP, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, MAXN, MAXN, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, MAXN, MAXP, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, MAXN, 0, 0, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_POLAR, -1, -1, MAXN, PI_A, 1'b0, '0},
    '{rcp_pkg::OP_TO_RECT, 0, 0, MAXP, 0, 1'b0, '0},
    '{rcp_pkg::OP_TO_RECT, 0, 0, MAXN, PI_A, 1'b0, '0},
    '{rcp_pkg::OP_TO_RECT, 0, 0, MAXP, -PI_A, 1'b0, '0},
    '{rcp_pkg::OP_TO_RECT, 0, 0, MAXP, 51472, 1'b0, '0},
    '{rcp_pkg::OP_TO_RECT, 0, 0, 65536, 262143, 1'b0, '0},
    '{rcp_pkg::OP_TO_RECT, 0, 0, 65536, -262144, 1'b0, '0},
    '{rcp_pkg::OP_TO_RECT, 0, 0, -65536, 102944, 1'b0, '0},
    '{rcp_pkg::OP_TO_RECT, 0, 0, MAXN, -102944, 1'b0, '0}
  };

  logic                              clk_i = 1'b0;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic                              op_i;
  logic signed [rcp_pkg::DATA_W-1:0] real_in_i;
  logic signed [rcp_pkg::DATA_W-1:0] imag_in_i;
  logic signed [rcp_pkg::DATA_W-1:0] mag_in_i;
  logic signed [rcp_pkg::ANG_W-1:0]  angle_in_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [rcp_pkg::DATA_W-1:0] real_out_o;
  logic signed [rcp_pkg::DATA_W-1:0] imag_out_o;
  logic signed [rcp_pkg::MAG_W-1:0]  mag_out_o;
  logic signed [rcp_pkg::ANG_W-1:0]  angle_out_o;

  conv_req_t cur_req;
  conv_res_t result_q [$];
  int n_err;
  int n_polar;
  int n_rect;
  int n_res;
  int n_backp;

  rect_polar_converter u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .real_in_i   (real_in_i),
    .imag_in_i   (imag_in_i),
    .mag_in_i    (mag_in_i),
    .angle_in_i  (angle_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .real_out_o  (real_out_o),
    .imag_out_o  (imag_out_o),
    .mag_out_o   (mag_out_o),
    .angle_out_o (angle_out_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic longint micro_angle(input int i);
    longint unsigned p;
    p = {32'd0, ATAN_TURN[i]} * TWO_PI_TURN;
    return longint'(p >> 28);
  endfunction

  function automatic logic signed [rcp_pkg::DATA_W-1:0] sat_data(input longint v);
    if (v > longint'(MAXP)) return MAXP;
    if (v < longint'(MAXN)) return MAXN;
    return rcp_pkg::DATA_W'(v);
  endfunction

  function automatic conv_res_t convert_item(input conv_req_t q);
    conv_res_t res;
    longint x, y, z, xs, ys, v, pi_f;
    int i;
    res.re  = q.re;
    res.im  = q.im;
    res.mag = q.mag;
    res.ang = q.ang;
    if (q.op == rcp_pkg::OP_TO_POLAR) begin
      x = q.re;
      y = q.im;
      if (x == 0 && y == 0) begin
        res.mag = '0;
        res.ang = '0;
        return res;
      end
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = (y <= 0) ? PI_RAD : -PI_RAD;
      end
      x = x <<< G_BITS;
      y = y <<< G_BITS;
      for (i = 0; i < N_ROT; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys;
          y -= xs;
          z += micro_angle(i);
        end else begin
          x -= ys;
          y += xs;
          z -= micro_angle(i);
        end
      end
      v = (x * K_GAIN + (64'sd1 <<< (24 + G_BITS - 1))) >>> (24 + G_BITS);
      res.mag = rcp_pkg::MAG_W'((v > MAG_CAP) ? MAG_CAP : v);
      pi_f = (PI_RAD + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
      v = (z + (64'sd1 <<< (ANG_SH - 1))) >>> ANG_SH;
      if (v > pi_f) v = pi_f;
      if (v < -pi_f) v = -pi_f;
      res.ang = rcp_pkg::ANG_W'(v);
    end else begin
      z = (longint'(q.ang) <<< ANG_SH) % TWO_PI_RAD;
      if (z > PI_RAD) z -= TWO_PI_RAD;
      if (z < -PI_RAD) z += TWO_PI_RAD;
      x = (longint'(q.mag) * K_GAIN + (64'sd1 <<< (24 - G_BITS - 1))) >>> (24 - G_BITS);
      y = 0;
      if (z > HALF_PI_RAD) begin
        z -= PI_RAD;
        x = -x;
      end else if (z < -HALF_PI_RAD) begin
        z += PI_RAD;
        x = -x;
      end
      for (i = 0; i < N_ROT; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= micro_angle(i);
        end else begin
          x += ys;
          y -= xs;
          z += micro_angle(i);
        end
      end
      res.re = sat_data((x + (64'sd1 <<< (G_BITS - 1))) >>> G_BITS);
      res.im = sat_data((y + (64'sd1 <<< (G_BITS - 1))) >>> G_BITS);
    end
    return res;
  endfunction

  task automatic cmp_field(input string nm, input logic signed [63:0] want,
                           input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm, want, got);
      n_err++;
    end
  endtask

  task automatic send_xfer(input conv_req_t q, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    cur_req = q;
    in_valid_i <= 1'b1;
    op_i       <= q.op;
    real_in_i  <= q.re;
    imag_in_i  <= q.im;
    mag_in_i   <= q.mag;
    angle_in_i <= q.ang;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : scoreboard
    conv_res_t want;
    conv_res_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{real_out_o, imag_out_o, mag_out_o, angle_out_o};
        n_res++;
        if (result_q.size() == 0) begin
          $display("%0t: result transfer with nothing pending, actual %0d %0d %0d %0d",
                   $time, got.re, got.im, got.mag, got.ang);
          n_err++;
        end else begin
          want = result_q.pop_front();
          cmp_field("real_out", want.re, got.re);
          cmp_field("imag_out", want.im, got.im);
          cmp_field("mag_out", want.mag, got.mag);
          cmp_field("angle_out", want.ang, got.ang);
        end
      end
      if (in_valid_i && !in_stall_o) begin
        result_q.push_back(cur_req.typed ? cur_req.want : convert_item(cur_req));
        if (cur_req.op == rcp_pkg::OP_TO_POLAR) n_polar++;
        else n_rect++;
      end
      if (in_valid_i && in_stall_o) n_backp++;
    end
  end

  initial begin : result_sink
    int hold;
    bit held;
    int pct;
    hold = 0;
    held = 1'b0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && n_polar + n_rect >= HOLD_AT) begin
        held = 1'b1;
        hold = HOLD_LEN;
      end
      pct = (n_polar + n_rect >= 150 && n_polar + n_rect < 450) ? 0 : 20;
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        hold--;
      end else begin
        out_stall_i <= ($urandom_range(99) < pct);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    conv_req_t req;
    logic signed [rcp_pkg::ANG_W-1:0] in_ang;
    int k;
    n_err = 0;
    n_polar = 0;
    n_rect = 0;
    n_res = 0;
    n_backp = 0;
    cur_req = '0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = 1'b0;
    real_in_i = '0;
    imag_in_i = '0;
    mag_in_i = '0;
    angle_in_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (k = 0; k < N_DIR; k++) send_xfer(DIR_ROWS[k], 20);

    for (k = 0; k < N_RAND; k++) begin
      req = '0;
      req.re  = $urandom;
      req.im  = $urandom;
      req.mag = $urandom;
      req.ang = rcp_pkg::ANG_W'($urandom);
      in_ang  = rcp_pkg::ANG_W'(int'($urandom_range(411774)) - 205887);
      case ($urandom_range(9))
        0, 1: req.op = rcp_pkg::OP_TO_POLAR;
        2: begin
          req.op = rcp_pkg::OP_TO_POLAR;
          req.re = rcp_pkg::DATA_W'(int'($urandom_range(2000)) - 1000);
          req.im = rcp_pkg::DATA_W'(int'($urandom_range(2000)) - 1000);
        end
        3: begin
          req.op = rcp_pkg::OP_TO_POLAR;
          if ($urandom_range(1)) req.re = '0;
          else req.im = '0;
        end
        4: begin
          req.op = rcp_pkg::OP_TO_POLAR;
          req.re = EDGE_VALS[$urandom_range(4)];
          req.im = EDGE_VALS[$urandom_range(4)];
        end
        5, 6: begin
          req.op  = rcp_pkg::OP_TO_RECT;
          req.ang = in_ang;
        end
        7: req.op = rcp_pkg::OP_TO_RECT;
        8: begin
          req.op  = rcp_pkg::OP_TO_RECT;
          req.mag = EDGE_VALS[$urandom_range(4)];
          req.ang = in_ang;
        end
        default: begin
          req.op  = rcp_pkg::OP_TO_RECT;
          req.mag = rcp_pkg::DATA_W'(int'($urandom_range(200000)) - 100000);
          req.ang = in_ang;
        end
      endcase
      send_xfer(req, (k >= 100 && k < 400) ? 0 : 20);
    end
    in_valid_i <= 1'b0;

    while (result_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("covered %0d to-polar and %0d to-rect conversions, %0d results compared",
             n_polar, n_rect, n_res);
    $display("input held back for %0d cycles by a stalled result side", n_backp);
    if (n_err == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[sim.f]
rtl/rcp_pkg.sv
rtl/rcp_prep.sv
rtl/rcp_cell.sv
rtl/rcp_post.sv
rtl/rect_polar_converter.sv
rtl/rcp_checker.sv
test/rect_polar_converter_test.sv
